// ----- design/rqbias_pkg.sv -----
// shared types and constants for the uint8 requantizing bias add
`timescale 1ns / 1ps

package rqbias_pkg;

    localparam int VAL_W      = 8;
    localparam int CHAN_W     = 10;
    localparam int CCNT_W     = 11;
    localparam int MULT_W     = 32;
    localparam int SUM_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROD_W     = DIFF_W + MULT_W + 1;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FRAC_W     = 24;
    localparam int CCNT_MAX   = (1 << CCNT_W) - 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ACT  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT    = 3'd0,
        CFG_INPUT_ZERO_POINT = 3'd1,
        CFG_BIAS_ZERO_POINT  = 3'd2,
        CFG_INPUT_MULTIPLIER = 3'd3,
        CFG_BIAS_MULTIPLIER  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [CCNT_W-1:0] channel_count;
        logic [VAL_W-1:0]  input_zero_point;
        logic [VAL_W-1:0]  bias_zero_point;
        logic [MULT_W-1:0] input_multiplier;
        logic [MULT_W-1:0] bias_multiplier;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] channel;
        logic              last;
    } tag_t;

    function automatic int eff_max(input int max_channels);
        return (max_channels > CCNT_MAX) ? CCNT_MAX : max_channels;
    endfunction

    function automatic int cnt_width(input int max_channels);
        int m;
        m = eff_max(max_channels);
        return (m > 1) ? $clog2(m) : 1;
    endfunction

endpackage

// ----- design/rqbias_chan_seq.sv -----
// channel counter that tags each activation with its channel and position end
`timescale 1ns / 1ps

module rqbias_chan_seq import rqbias_pkg::*; #(
    parameter int MAX_CHANNELS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 act_xfer,
    input  logic                                 load_xfer,
    input  logic [CCNT_W-1:0]                    channel_count,
    output tag_t                                 tag,
    output logic [CCNT_W-1:0]                    rd_ch,
    output logic [cnt_width(MAX_CHANNELS)-1:0]   ctr
);

    localparam int CNT_W = cnt_width(MAX_CHANNELS);
    localparam logic [CCNT_W-1:0] N_MAX = CCNT_W'(eff_max(MAX_CHANNELS));

    logic [CNT_W-1:0]  ctr_reg;
    logic [CNT_W-1:0]  ctr_next;
    logic [CCNT_W-1:0] n_eff;
    logic [CCNT_W-1:0] ctr_ext;
    logic [CCNT_W-1:0] ch_eff;
    logic              last;

    always_comb begin
        if (channel_count == '0) begin
            n_eff = CCNT_W'(1);
        end else if (channel_count > N_MAX) begin
            n_eff = N_MAX;
        end else begin
            n_eff = channel_count;
        end
    end

    assign ctr_ext = CCNT_W'(ctr_reg);
    assign ch_eff  = (ctr_ext >= n_eff) ? '0 : ctr_ext;
    assign last    = (ch_eff == n_eff - CCNT_W'(1));

    always_comb begin
        ctr_next = ctr_reg;
        if (load_xfer) begin
            ctr_next = '0;
        end else if (act_xfer) begin
            ctr_next = last ? '0 : CNT_W'(ch_eff + CCNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
        end else begin
            ctr_reg <= ctr_next;
        end
    end

    assign tag.valid   = act_xfer;
    assign tag.channel = CHAN_W'(ch_eff);
    assign tag.last    = last;
    assign rd_ch       = ch_eff;
    assign ctr         = ctr_reg;

endmodule

// ----- design/rqbias_bias_mem.sv -----
// per-channel bias table, one write port and one registered read port
`timescale 1ns / 1ps

module rqbias_bias_mem import rqbias_pkg::*; #(
    parameter int MAX_CHANNELS = 1024
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [CHAN_W-1:0] wr_idx,
    input  logic [VAL_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [CCNT_W-1:0] rd_ch,
    output logic [VAL_W-1:0]  rd_data
);

    localparam int MEM_D = (MAX_CHANNELS < (1 << CHAN_W)) ? MAX_CHANNELS : (1 << CHAN_W);
    localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;

    logic [VAL_W-1:0] mem [MEM_D];
    logic [VAL_W-1:0] rd_data_reg;
    logic             wr_ok;

    assign wr_ok = wr_en && (32'(wr_idx) < 32'(MAX_CHANNELS));

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[AW'(wr_idx)] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[AW'(rd_ch)];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rqbias_datapath.sv -----
// offset, multiply, sum, round and saturate pipeline with output register
`timescale 1ns / 1ps

module rqbias_datapath import rqbias_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  tag_t              in_tag,
    input  logic [VAL_W-1:0]  in_value,
    input  logic [VAL_W-1:0]  bias_rd,
    input  cfg_t              cfg,
    output logic              out_valid,
    output logic [SUM_W-1:0]  out_sum,
    output logic [CHAN_W-1:0] out_channel,
    output logic              out_last
);

    localparam int Q_W = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0] HALF_Q = ACC_W'(64'd1 << (FRAC_W - 1));
    localparam logic signed [Q_W-1:0]   Q_MAX  = Q_W'((64'd1 << (SUM_W - 1)) - 64'd1);
    localparam logic signed [Q_W-1:0]   Q_MIN  = -Q_MAX - Q_W'(1);

    tag_t                      s1_tag_reg;
    logic signed [DIFF_W-1:0]  s1_dx_reg;
    tag_t                      s2_tag_reg;
    logic signed [PROD_W-1:0]  s2_px_reg;
    logic signed [PROD_W-1:0]  s2_pb_reg;
    tag_t                      s3_tag_reg;
    logic signed [ACC_W-1:0]   s3_acc_reg;
    logic                      m_valid_reg;
    logic [SUM_W-1:0]          m_sum_reg;
    logic [CHAN_W-1:0]         m_channel_reg;
    logic                      m_last_reg;

    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  db;
    logic signed [PROD_W-1:0]  px;
    logic signed [PROD_W-1:0]  pb;
    logic signed [ACC_W-1:0]   acc;
    logic signed [Q_W-1:0]     q_floor;
    logic signed [Q_W-1:0]     q_trunc;
    logic                      rnd_up;
    logic [SUM_W-1:0]          q_sat;

    assign dx  = DIFF_W'(in_value) - DIFF_W'(cfg.input_zero_point);
    assign db  = DIFF_W'(bias_rd) - DIFF_W'(cfg.bias_zero_point);
    assign px  = s1_dx_reg * $signed({1'b0, cfg.input_multiplier});
    assign pb  = db * $signed({1'b0, cfg.bias_multiplier});
    assign acc = ACC_W'(s2_px_reg) + ACC_W'(s2_pb_reg) + HALF_Q;

    // toward-zero division by 2^24
    assign q_floor = s3_acc_reg[ACC_W-1:FRAC_W];
    assign rnd_up  = s3_acc_reg[ACC_W-1] && (|s3_acc_reg[FRAC_W-1:0]);
    assign q_trunc = q_floor + $signed({{(Q_W-1){1'b0}}, rnd_up});

    always_comb begin
        if (q_trunc > Q_MAX) begin
            q_sat = Q_MAX[SUM_W-1:0];
        end else if (q_trunc < Q_MIN) begin
            q_sat = Q_MIN[SUM_W-1:0];
        end else begin
            q_sat = q_trunc[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg.valid <= 1'b0;
            s2_tag_reg.valid <= 1'b0;
            s3_tag_reg.valid <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else if (adv) begin
            s1_tag_reg  <= in_tag;
            s2_tag_reg  <= s1_tag_reg;
            s3_tag_reg  <= s2_tag_reg;
            m_valid_reg <= s3_tag_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_dx_reg     <= dx;
            s2_px_reg     <= px;
            s2_pb_reg     <= pb;
            s3_acc_reg    <= acc;
            m_sum_reg     <= q_sat;
            m_channel_reg <= s3_tag_reg.channel;
            m_last_reg    <= s3_tag_reg.last;
        end
    end

    assign out_valid   = m_valid_reg;
    assign out_sum     = m_sum_reg;
    assign out_channel = m_channel_reg;
    assign out_last    = m_last_reg;

endmodule

// ----- design/uint8_requant_bias_add_core.sv -----
// top level of the uint8 requantizing bias add with per-channel bias table
//
//  channel   ports                                   direction
//  input     s_valid s_ready s_op s_value s_bias_index   in
//  result    m_valid m_ready m_sum_value m_channel m_last_in_position   out
//  config    cfg_valid cfg_ready cfg_index cfg_data   in
//
//  one item per cycle while no result waits on m_ready; an activation result passes the
//  bias table read, multiply, sum, round and saturate stages into the output register
//  a bias load is written to the table at its transfer and gives no result
//  synchronous active-low reset clears the channel counter and pipeline valids and
//  sets the config to its defaults; the bias table is not cleared
//  while a result waits on m_ready every stage holds and s_ready is low
`timescale 1ns / 1ps

module uint8_requant_bias_add_core import rqbias_pkg::*; #(
    parameter int MAX_CHANNELS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [VAL_W-1:0]      s_value,
    input  logic [CHAN_W-1:0]     s_bias_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [SUM_W-1:0] m_sum_value,
    output logic [CHAN_W-1:0]     m_channel,
    output logic                  m_last_in_position,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = cnt_width(MAX_CHANNELS);

    cfg_t              cfg_reg;
    logic              adv;
    logic              act_xfer;
    logic              load_xfer;
    tag_t              act_tag;
    logic [CCNT_W-1:0] rd_ch;
    logic [CNT_W-1:0]  ctr;
    logic [VAL_W-1:0]  bias_rd;
    logic [SUM_W-1:0]  sum_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count    <= CCNT_W'(1);
            cfg_reg.input_zero_point <= '0;
            cfg_reg.bias_zero_point  <= '0;
            cfg_reg.input_multiplier <= MULT_W'(32'h0100_0000);
            cfg_reg.bias_multiplier  <= MULT_W'(32'h0100_0000);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CHANNEL_COUNT: begin
                    cfg_reg.channel_count <= cfg_data[CCNT_W-1:0];
                end
                CFG_INPUT_ZERO_POINT: begin
                    cfg_reg.input_zero_point <= cfg_data[VAL_W-1:0];
                end
                CFG_BIAS_ZERO_POINT: begin
                    cfg_reg.bias_zero_point <= cfg_data[VAL_W-1:0];
                end
                CFG_INPUT_MULTIPLIER: begin
                    cfg_reg.input_multiplier <= cfg_data[MULT_W-1:0];
                end
                CFG_BIAS_MULTIPLIER: begin
                    cfg_reg.bias_multiplier <= cfg_data[MULT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign act_xfer  = s_valid && s_ready && (s_op == OP_ACT);
    assign load_xfer = s_valid && s_ready && (s_op == OP_LOAD);

    rqbias_chan_seq #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_chan_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .act_xfer      (act_xfer),
        .load_xfer     (load_xfer),
        .channel_count (cfg_reg.channel_count),
        .tag           (act_tag),
        .rd_ch         (rd_ch),
        .ctr           (ctr)
    );

    rqbias_bias_mem #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_bias_mem (
        .aclk    (aclk),
        .wr_en   (load_xfer),
        .wr_idx  (s_bias_index),
        .wr_data (s_value),
        .rd_en   (adv),
        .rd_ch   (rd_ch),
        .rd_data (bias_rd)
    );

    rqbias_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_tag      (act_tag),
        .in_value    (s_value),
        .bias_rd     (bias_rd),
        .cfg         (cfg_reg),
        .out_valid   (m_valid),
        .out_sum     (sum_out),
        .out_channel (m_channel),
        .out_last    (m_last_in_position)
    );

    assign m_sum_value = $signed(sum_out);

    // a bias load restarts the channel sequence
    a_load_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        load_xfer |=> (ctr == '0))
        else $error("channel counter not cleared by bias load");

    // the counter only moves on an input transfer
    a_ctr_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) |=> $stable(ctr))
        else $error("channel counter moved without a transfer");

endmodule
